// ----- hdl/tea_pkg.sv -----
// ----------------------------------------------------------------------------
// tea_pkg
// Shared constants and the TEA round function for the block cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int WORD_W = 32;
  localparam int RC_W   = 6;
  // Round count after saturation; one bit wider than the register.
  localparam int CNT_W  = RC_W + 1;
  localparam int IDX_W  = 3;

  // Register map
  localparam logic [IDX_W-1:0] REG_KEY_A  = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_B  = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_C  = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY_D  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROUNDS = 3'd4;
  localparam logic [IDX_W-1:0] REG_DELTA  = 3'd5;

  localparam logic [RC_W-1:0]   ROUNDS_RST = 6'd32;
  localparam logic [WORD_W-1:0] DELTA_RST  = 32'h9E37_79B9;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] v,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb,
    input logic [WORD_W-1:0] sum
  );
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = (v << 4) + ka;
    b = v + sum;
    c = (v >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// ----- hdl/tea_block_cipher.sv -----
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt/decrypt of 64-bit blocks, ECB, one half-round per pipe stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode (0 encrypt, 1 decrypt),
//   block_high, block_low and last_block. Output channel (out_valid/out_stall)
//   returns out_high, out_low and out_last, one result per block, in order.
//   Key words, round count and delta are written through cfg_we/cfg_index/
//   cfg_data while the pipe is empty.
//   Throughput: one block per cycle while in_stall is low. Every block walks
//   2*MAX_ROUNDS half-round stages regardless of its round count; stages past
//   the count pass it on. Path: a block passes the input register, which
//   loads at the transfer, then the half-round stages and the output register
//   before out_valid rises.
//   Decrypt start sum (delta times the round count, saturated at MAX_ROUNDS)
//   is formed by a 32x7 multiply in the input register stage.
//   Reset: pipe empties, registers return to zero keys, 32 rounds and
//   delta 0x9E3779B9.
//   Stall: a skid register behind the output catches the one result in
//   flight; in_stall rises while it is occupied and the whole pipe holds.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tea_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [31:0]               block_high,
  input  logic [31:0]               block_low,
  input  logic                      last_block,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_high,
  output logic [31:0]               out_low,
  output logic                      out_last
);
  import tea_pkg::*;

  localparam int STAGES = 2 * MAX_ROUNDS;

  // Configuration registers
  logic [WORD_W-1:0] key_a, key_b, key_c, key_d, delta;
  logic [RC_W-1:0]   rounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a  <= '0;
      key_b  <= '0;
      key_c  <= '0;
      key_d  <= '0;
      rounds <= ROUNDS_RST;
      delta  <= DELTA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_A:  key_a  <= cfg_data;
        REG_KEY_B:  key_b  <= cfg_data;
        REG_KEY_C:  key_c  <= cfg_data;
        REG_KEY_D:  key_d  <= cfg_data;
        REG_ROUNDS: rounds <= cfg_data[RC_W-1:0];
        REG_DELTA:  delta  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_act;
  assign n_act = ({1'b0, rounds} > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS)
                                                       : {1'b0, rounds};

  logic [WORD_W+CNT_W-1:0] dec_start;
  assign dec_start = delta * n_act;

  // Pipe registers; index 0 is the input register
  logic              v    [STAGES+1];
  logic              op   [STAGES+1];
  logic              last [STAGES+1];
  logic [WORD_W-1:0] y    [STAGES+1];
  logic [WORD_W-1:0] z    [STAGES+1];
  logic [WORD_W-1:0] sum  [STAGES+1];

  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op[0]   <= opcode;
      last[0] <= last_block;
      y[0]    <= block_high;
      z[0]    <= block_low;
      // encrypt carries the sum for the current round, starting at delta
      sum[0]  <= (opcode == OP_DECRYPT) ? dec_start[WORD_W-1:0] : delta;
    end
  end

  for (genvar h = 0; h < STAGES; h++) begin : g_half
    localparam int RND = h / 2;
    localparam bit ODD = (h % 2) == 1;

    logic              act;
    logic [WORD_W-1:0] y_next, z_next, sum_next;

    assign act = CNT_W'(RND) < n_act;

    always_comb begin
      y_next   = y[h];
      z_next   = z[h];
      sum_next = sum[h];
      if (act) begin
        if (op[h] == OP_ENCRYPT) begin
          if (!ODD) begin
            y_next = y[h] + mix(z[h], key_a, key_b, sum[h]);
          end else begin
            z_next   = z[h] + mix(y[h], key_c, key_d, sum[h]);
            sum_next = sum[h] + delta;
          end
        end else begin
          if (!ODD) begin
            z_next = z[h] - mix(y[h], key_c, key_d, sum[h]);
          end else begin
            y_next   = y[h] - mix(z[h], key_a, key_b, sum[h]);
            sum_next = sum[h] - delta;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[h+1] <= 1'b0;
      end else if (en) begin
        v[h+1] <= v[h];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op[h+1]   <= op[h];
        last[h+1] <= last[h];
        y[h+1]    <= y_next;
        z[h+1]    <= z_next;
        sum[h+1]  <= sum_next;
      end
    end
  end

  // Output register plus skid
  logic              out_ready;
  logic [WORD_W-1:0] skid_high, skid_low;
  logic              skid_last;

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (v[STAGES]) begin
      if (out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_high <= skid_high;
        out_low  <= skid_low;
        out_last <= skid_last;
      end
    end else if (v[STAGES]) begin
      if (out_ready) begin
        out_high <= y[STAGES];
        out_low  <= z[STAGES];
        out_last <= last[STAGES];
      end else begin
        skid_high <= y[STAGES];
        skid_low  <= z[STAGES];
        skid_last <= last[STAGES];
      end
    end
  end

  // A result only parks in the skid when the output was full and stalled
  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output register is empty");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> ($stable(v[STAGES]) && $stable(y[STAGES]) && $stable(z[STAGES])))
    else $error("pipe advanced while skid was occupied");

endmodule
